// ===== rtl/core/sha_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 stream hasher.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package sha_pkg;

	localparam int HASH_WORDS = 8;
	localparam int WIN_WORDS  = 16;
	localparam int ROUNDS     = 64;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LENGTH_POS = 6'd56;
	localparam logic [5:0] LAST_FILL  = 6'd63;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       message_end;
	} sha_req_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} sha_rsp_t;

	typedef enum logic [1:0] {
		SEL_DATA,
		SEL_MARK,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic      push;
		byte_sel_t sel;
		logic      count;
		logic      latch_len;
		logic      init;
		logic      round;
		logic [5:0] rnd;
		logic      fin;
		logic      emit;
		logic [2:0] idx;
		logic      restart;
	} sha_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       out_free;
	} sha_stat_t;

	typedef logic [HASH_WORDS-1:0][31:0] hash_t;

	localparam hash_t INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		logic [63:0] d;
		d = {x, x} >> n;
		return d[31:0];
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'h428a2f98;   6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;   6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;   6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;   6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;   6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/core/sha_ctrl.sv =====
// Sequencing controller: request intake, padding, round count and digest output.
// Depends on sha_pkg; drives the datapath through sha_cmd_t only.
`timescale 1ns / 1ps

module sha_ctrl import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  sha_req_t  byte_req,
	input  sha_stat_t stat,
	output sha_cmd_t  cmd
);

	typedef enum logic [2:0] {S_IDLE, S_COMP, S_FIN, S_PAD, S_EMIT} state_t;
	typedef enum logic [1:0] {P_MARK, P_ZERO, P_LEN} phase_t;

	state_t     state_q;
	phase_t     phase_q;
	logic [5:0] rnd_q;
	logic [2:0] idx_q;
	logic       end_q;
	logic       done_q;
	logic       accept;
	logic       full;
	logic       len_byte;

	assign byte_stall = (state_q != S_IDLE);
	assign accept     = byte_valid && (state_q == S_IDLE);
	assign full       = (stat.fill == LAST_FILL);
	// Length bytes start once zero fill has reached the length field.
	assign len_byte   = (phase_q == P_LEN) || (phase_q == P_ZERO && stat.fill == LENGTH_POS);

	always_comb begin
		cmd = '0;
		cmd.rnd = rnd_q;
		cmd.idx = idx_q;
		cmd.sel = SEL_DATA;
		case (state_q)
			S_IDLE: begin
				cmd.push      = accept && byte_req.byte_present;
				cmd.count     = cmd.push;
				cmd.latch_len = accept && byte_req.message_end;
				cmd.init      = cmd.push && full;
			end
			S_COMP: cmd.round = 1'b1;
			S_FIN:  cmd.fin = 1'b1;
			S_PAD: begin
				cmd.push = 1'b1;
				cmd.init = full;
				if (phase_q == P_MARK) begin
					cmd.sel = SEL_MARK;
				end else if (len_byte) begin
					cmd.sel = SEL_LEN;
				end else begin
					cmd.sel = SEL_ZERO;
				end
			end
			S_EMIT: begin
				cmd.emit    = stat.out_free;
				cmd.restart = stat.out_free && (idx_q == 3'd7);
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= P_MARK;
			rnd_q   <= '0;
			idx_q   <= '0;
			end_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					phase_q <= P_MARK;
					rnd_q   <= '0;
					if (accept) begin
						end_q <= byte_req.message_end;
						if (byte_req.byte_present && full) begin
							state_q <= S_COMP;
						end else if (byte_req.message_end) begin
							state_q <= S_PAD;
						end
					end
				end
				S_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(ROUNDS - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					idx_q <= '0;
					if (done_q) begin
						state_q <= S_EMIT;
					end else if (end_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_PAD: begin
					if (phase_q == P_MARK) begin
						phase_q <= P_ZERO;
					end else if (len_byte) begin
						phase_q <= P_LEN;
					end
					if (full) begin
						rnd_q   <= '0;
						done_q  <= len_byte;
						state_q <= S_COMP;
					end
				end
				S_EMIT: begin
					if (stat.out_free) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							end_q   <= 1'b0;
							done_q  <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_rounds_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMP && rnd_q == 6'd63) |=> (state_q == S_FIN))
		else $error("compression did not finish after the last round");

	a_pad_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PAD && stat.fill == LAST_FILL) |=> (state_q == S_COMP && rnd_q == 6'd0))
		else $error("full padded block did not start compression");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (done_q && end_q))
		else $error("digest output without a finished message");

	a_len_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PAD && phase_q == P_LEN) |-> (stat.fill >= LENGTH_POS))
		else $error("length byte outside the length field");

endmodule

// ===== rtl/core/sha_dp.sv =====
// Datapath: block shift window, bit counter, round logic, chaining hash, output register.
// Depends on sha_pkg; controlled by sha_ctrl through sha_cmd_t.
`timescale 1ns / 1ps

module sha_dp import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [7:0] data_byte,
	input  sha_cmd_t  cmd,
	output sha_stat_t stat,
	output logic      digest_valid,
	input  logic      digest_stall,
	output sha_rsp_t  digest_rsp
);

	logic [WIN_WORDS*32-1:0] win_q;
	hash_t       hash_q;
	hash_t       work_q;
	logic [5:0]  fill_q;
	logic [63:0] count_q;
	logic [63:0] len_q;
	logic        valid_q;
	sha_rsp_t    rsp_q;
	logic [7:0]  push_byte;
	logic [63:0] len_shift;
	logic [31:0] w0, w1, w9, w14, w_new;
	logic [31:0] sum1, sum2;

	assign len_shift = len_q >> {3'd7 - fill_q[2:0], 3'b000};

	always_comb begin
		case (cmd.sel)
			SEL_DATA: push_byte = data_byte;
			SEL_MARK: push_byte = PAD_BYTE;
			SEL_ZERO: push_byte = 8'h00;
			SEL_LEN:  push_byte = len_shift[7:0];
			default:  push_byte = 8'h00;
		endcase
	end

	// The window holds the block with its oldest word at the top; during the
	// rounds it shifts as the sixteen-word message schedule.
	assign w0  = win_q[511:480];
	assign w1  = win_q[479:448];
	assign w9  = win_q[223:192];
	assign w14 = win_q[63:32];
	assign w_new = w0 + small_s0(w1) + w9 + small_s1(w14);

	assign sum1 = work_q[7] + big_s1(work_q[4])
		+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
		+ round_k(cmd.rnd) + w0;
	assign sum2 = big_s0(work_q[0])
		+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			win_q <= {win_q[WIN_WORDS*32-9:0], push_byte};
		end else if (cmd.round) begin
			win_q <= {win_q[WIN_WORDS*32-33:0], w_new};
		end
		if (cmd.init) begin
			work_q <= hash_q;
		end else if (cmd.round) begin
			work_q <= {work_q[6:4], work_q[3] + sum1, work_q[2:0], sum1 + sum2};
		end
		if (cmd.latch_len) begin
			len_q <= count_q + (cmd.count ? 64'd8 : 64'd0);
		end
		if (cmd.emit) begin
			rsp_q.digest_word <= hash_q[cmd.idx];
			rsp_q.word_index  <= cmd.idx;
			rsp_q.last_word   <= (cmd.idx == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q  <= INIT_HASH;
			fill_q  <= '0;
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				hash_q  <= INIT_HASH;
				fill_q  <= '0;
				count_q <= '0;
			end else begin
				if (cmd.fin) begin
					for (int i = 0; i < HASH_WORDS; i++) begin
						hash_q[i] <= hash_q[i] + work_q[i];
					end
				end
				if (cmd.push) begin
					fill_q <= fill_q + 6'd1;
				end
				if (cmd.count) begin
					count_q <= count_q + 64'd8;
				end
			end
			if (cmd.emit) begin
				valid_q <= 1'b1;
			end else if (!digest_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign stat.fill     = fill_q;
	assign stat.out_free = !valid_q || !digest_stall;
	assign digest_valid  = valid_q;
	assign digest_rsp    = rsp_q;

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.restart |=> (fill_q == 6'd0 && count_q == 64'd0))
		else $error("message state not cleared after the digest");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!valid_q || !digest_stall))
		else $error("digest word overwrote a waiting word");

	a_no_push_round: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.round))
		else $error("byte push during a compression round");

endmodule

// ===== rtl/core/sha256_stream_hasher.sv =====
// SHA-256 stream hasher: at most one message byte per request, digest as eight words.
// A byte that fills a block stalls intake through the rounds and the hash add.
// Throughput: one byte per cycle within a block; intake stalls while a full block is compressed.
// End of message: one pad byte per cycle, each padded block compressed, then 8 output words.
// Reset (arst_n low, asynchronous) loads the initial hash and clears fill and bit count.
`timescale 1ns / 1ps

module sha256_stream_hasher import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_stall,
	input  sha_req_t byte_req,
	output logic     digest_valid,
	input  logic     digest_stall,
	output sha_rsp_t digest_rsp
);

	sha_cmd_t  cmd;
	sha_stat_t stat;

	sha_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_req   (byte_req),
		.stat       (stat),
		.cmd        (cmd)
	);

	sha_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (byte_req.data_byte),
		.cmd          (cmd),
		.stat         (stat),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest_rsp   (digest_rsp)
	);

endmodule

// ===== verif/sha256_checker.sv =====
// Checker for the SHA-256 stream hasher: predicts digests from accepted requests
// and compares every accepted digest word. Depends on sha_pkg only for the port types.
`timescale 1ns / 1ps

module sha256_checker import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	input  logic     byte_stall,
	input  sha_req_t byte_req,
	input  logic     digest_valid,
	input  logic     digest_stall,
	input  sha_rsp_t digest_rsp,
	output int       fail_count,
	output int       pending_words,
	output int       digests_seen
);

	logic [31:0] hash_state [8];
	logic [7:0]  msg_block [64];
	int          block_fill;
	logic [63:0] bit_length;
	sha_rsp_t    expected_words [$];

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] k_const(input int i);
		logic [31:0] tbl [64];
		tbl = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
			32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
			32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
			32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
			32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return tbl[i];
	endfunction

	task automatic start_message();
		hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		block_fill = 0;
		bit_length = '0;
	endtask

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
		v = hash_state;
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(i) + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] = hash_state[i] + v[i];
	endtask

	task automatic append_byte(input logic [7:0] b);
		msg_block[block_fill] = b;
		block_fill++;
		if (block_fill == 64) begin
			compress_block();
			block_fill = 0;
		end
	endtask

	task automatic absorb_request(input sha_req_t r);
		logic [63:0] len;
		sha_rsp_t w;
		if (r.byte_present) begin
			bit_length += 64'd8;
			append_byte(r.data_byte);
		end
		if (r.message_end) begin
			len = bit_length;
			append_byte(8'h80);
			while (block_fill != 56)
				append_byte(8'h00);
			for (int i = 0; i < 8; i++)
				append_byte(len[63-8*i -: 8]);
			for (int i = 0; i < 8; i++) begin
				w.digest_word = hash_state[i];
				w.word_index = 3'(i);
				w.last_word = (i == 7);
				expected_words.push_back(w);
			end
			start_message();
		end
	endtask

	assign pending_words = expected_words.size();

	always @(posedge clk or negedge arst_n) begin
		sha_rsp_t want;
		if (!arst_n) begin
			start_message();
			expected_words.delete();
			fail_count <= 0;
			digests_seen <= 0;
		end else begin
			if (byte_valid && !byte_stall)
				absorb_request(byte_req);
			if (digest_valid && !digest_stall) begin
				if (expected_words.size() == 0) begin
					if (fail_count < 10)
						$display("Unexpected digest word %h idx %0d", digest_rsp.digest_word,
							digest_rsp.word_index);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_words.pop_front();
					if (want !== digest_rsp) begin
						if (fail_count < 10)
							$display("Mismatch: expected %h/%0d/%b got %h/%0d/%b",
								want.digest_word, want.word_index, want.last_word,
								digest_rsp.digest_word, digest_rsp.word_index,
								digest_rsp.last_word);
						fail_count <= fail_count + 1;
					end
					if (want.last_word)
						digests_seen <= digests_seen + 1;
				end
			end
		end
	end

endmodule

// ===== verif/testbench.sv =====
// Top of the SHA-256 stream hasher testbench: clock, reset, request stimulus and
// verdict. Depends on sha_pkg, the hasher RTL and sha256_checker.
`timescale 1ns / 1ps

module testbench;
	import sha_pkg::*;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     byte_valid = 1'b0;
	logic     byte_stall;
	sha_req_t byte_req = '0;
	logic     digest_valid;
	logic     digest_stall = 1'b0;
	sha_rsp_t digest_rsp;
	int       fail_count, pending_words, digests_seen;
	int       send_idle_pct = 9, recv_idle_pct = 54;
	int       hold_off = 0;
	int       requests_sent = 0;
	longint   cycle_count = 0;

	always #5 clk = ~clk;

	sha256_stream_hasher DUT (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(byte_valid), .byte_stall(byte_stall), .byte_req(byte_req),
		.digest_valid(digest_valid), .digest_stall(digest_stall), .digest_rsp(digest_rsp)
	);

	sha256_checker digest_checker (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(byte_valid), .byte_stall(byte_stall), .byte_req(byte_req),
		.digest_valid(digest_valid), .digest_stall(digest_stall), .digest_rsp(digest_rsp),
		.fail_count(fail_count), .pending_words(pending_words), .digests_seen(digests_seen)
	);

	// Receiver: random stall, or a long hold-off while the sender keeps pushing.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			digest_stall <= 1'b1;
		end else
			digest_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offers one request, with random idle cycles beforehand, and waits for acceptance.
	task automatic send_request(input logic [7:0] b, input logic present, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_req <= '{data_byte: b, byte_present: present, message_end: fin};
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		requests_sent++;
	endtask

	task automatic send_message(input int len, input bit end_with_byte);
		for (int i = 0; i < len; i++)
			send_request(8'($urandom), 1'b1, end_with_byte && i == len - 1);
		if (!end_with_byte || len == 0)
			send_request(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: empty message, "abc", idle item, byte extremes.
		send_request(8'hff, 1'b0, 1'b1);
		send_request(8'h61, 1'b1, 1'b0);
		send_request(8'h00, 1'b0, 1'b0);
		send_request(8'h62, 1'b1, 1'b0);
		send_request(8'h63, 1'b1, 1'b1);
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'hff, 1'b1, 1'b1);
		// A message of exactly one block whose last byte also ends it.
		send_message(64, 1'b1);
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct = 54;
				recv_idle_pct = 9;
				hold_off = 400;
			end else if (phase == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int m = 0; m < 5; m++) begin
				if ($urandom_range(9) == 0)
					send_request(8'($urandom), 1'b0, 1'b0);
				send_message(int'($urandom_range(6)), 1'($urandom_range(1)));
			end
		end
		byte_valid <= 1'b0;
		while (pending_words != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d requests; %0d digests checked across empty, one-block",
			requests_sent, digests_seen);
		$display("and short random messages under three stall patterns and a hold-off.");
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
